FILE: src/gesl_pkg.sv
// Package with shared types and constants for the graph edge store and component labeller.
`timescale 1ns / 1ps
package gesl_pkg;
  localparam int unsigned NumVertices = 64;
  localparam int unsigned VtxW = 6;
  localparam int unsigned CntW = 7;

  typedef enum logic [1:0] {
    CmdInsert = 2'd0,
    CmdRemove = 2'd1,
    CmdQuery  = 2'd2,
    CmdLabel  = 2'd3
  } cmd_e;

  typedef enum logic [3:0] {
    StIdle,
    StClear,
    StRdU,
    StWrU,
    StRdV,
    StWrV,
    StScan,
    StPop,
    StNbr,
    StEmit,
    StEmitRd,
    StOut
  } state_e;
endpackage

FILE: src/graph_edge_store_component_labeler.sv
// Top level of the graph edge store and connected-component labeller.
`timescale 1ns / 1ps
// Usage: the slave channel takes one command beat holding cmd, vertex_u and vertex_v.
// The master channel returns result beats of status, edge_present, vertex_index and
// component_label, with tlast on the final beat of each command. Edge commands give one
// beat; a label command gives one beat per vertex in use, in vertex order.
// The adjacency matrix lives in a 64 x 64-bit memory with a registered read port.
// Insert and remove read, modify and write back row u and then row v; their result beat
// follows the states StRdU, StWrU, StRdV, StWrV and StOut. A query or an out-of-range
// command goes from StRdU straight to StOut. The slave side stays low while a result
// beat waits, and a new command is only taken once the last one has been finished.
// Labelling clears the visited marks as the command is accepted, then walks depth first:
// it scans the vertices in order, pops the stack and pushes each unvisited neighbour.
// The labels then go out one beat per vertex, each through StEmit, StEmitRd and StOut.
// After reset the block sweeps the adjacency memory clear before it accepts
// a command; vertex_count resets to 64. The register may be written at any time while
// idle. One command is worked on at a time; a stalled receiver holds the result beat
// and the block waits until it is taken.
module graph_edge_store_component_labeler (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [6:0]  cfg_wdata_i,  // vertex_count
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // cmd[1:0], vertex_u[7:2], vertex_v[13:8], zeros
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // status[0], edge_present[1], vertex_index[7:2],
                                     // component_label[13:8], zeros
  output logic        m_axis_tlast
);
  import gesl_pkg::*;

  logic [NumVertices-1:0] adj_mem [NumVertices];
  logic [VtxW-1:0] lbl_mem [NumVertices];
  logic [VtxW-1:0] stk_mem [NumVertices];

  state_e state_q, state_d;
  logic [CntW-1:0] vcnt_q;
  logic [VtxW-1:0] n_m1;
  logic [NumVertices-1:0] inuse;
  logic [1:0] cmd_q;
  logic [VtxW-1:0] u_q, v_q;
  logic [CntW-1:0] idx_q, idx_d;
  logic [NumVertices-1:0] vis_q, vis_d;
  logic [NumVertices-1:0] nb_q, nb_d;
  logic [CntW-1:0] sp_q, sp_d;
  logic [VtxW-1:0] lab_q, lab_d;
  logic [NumVertices-1:0] row_q;
  logic [VtxW-1:0] stk_rd_q, lbl_rd_q;
  logic [VtxW-1:0] top_q, stk_top;
  logic top_fwd_q;
  logic [15:0] out_data_q, out_data_d;
  logic out_last_q, out_last_d, out_valid_q, out_valid_d;
  state_e ret_q, ret_d;

  logic adj_we, lbl_we, stk_we;
  logic [VtxW-1:0] adj_wa, adj_ra, lbl_wa, lbl_ra, stk_wa, stk_ra, lbl_wd, stk_wd;
  logic [NumVertices-1:0] adj_wd;
  logic [VtxW-1:0] nb_first;
  logic oob;

  always_comb begin
    logic [CntW-1:0] n;
    n = vcnt_q;
    if (n == '0) n = CntW'(1);
    if (n > CntW'(NumVertices)) n = CntW'(NumVertices);
    n_m1 = VtxW'(n - CntW'(1));
    for (int i = 0; i < NumVertices; i++) inuse[i] = (CntW'(i) < n);
  end

  always_comb begin
    nb_first = '0;
    for (int i = NumVertices - 1; i >= 0; i--) begin
      if (nb_q[i]) begin
        nb_first = VtxW'(i);
      end
    end
  end

  assign oob = (u_q > n_m1) || (v_q > n_m1);

  // The top of the stack may have been written in the same cycle that it was read.
  assign stk_top = top_fwd_q ? top_q : stk_rd_q;

  always_ff @(posedge clk_i) begin
    if (adj_we) adj_mem[adj_wa] <= adj_wd;
    row_q <= adj_mem[adj_ra];
    if (lbl_we) lbl_mem[lbl_wa] <= lbl_wd;
    lbl_rd_q <= lbl_mem[lbl_ra];
    if (stk_we) stk_mem[stk_wa] <= stk_wd;
    stk_rd_q <= stk_mem[stk_ra];
    top_q <= stk_wd;
    top_fwd_q <= stk_we && (stk_wa == stk_ra);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
      ret_q <= StIdle;
      vcnt_q <= CntW'(NumVertices);
      idx_q <= '0;
      vis_q <= '0;
      nb_q <= '0;
      sp_q <= '0;
      lab_q <= '0;
      out_valid_q <= 1'b0;
      out_last_q <= 1'b0;
      out_data_q <= '0;
    end else begin
      state_q <= state_d;
      ret_q <= ret_d;
      if (cfg_we_i) vcnt_q <= cfg_wdata_i;
      idx_q <= idx_d;
      vis_q <= vis_d;
      nb_q <= nb_d;
      sp_q <= sp_d;
      lab_q <= lab_d;
      out_valid_q <= out_valid_d;
      out_last_q <= out_last_d;
      out_data_q <= out_data_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      cmd_q <= s_axis_tdata[1:0];
      u_q <= s_axis_tdata[7:2];
      v_q <= s_axis_tdata[13:8];
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (s_axis_tvalid && !out_valid_q) begin
          state_d = (s_axis_tdata[1:0] == CmdLabel) ? StScan : StRdU;
        end
      end
      StClear:  if (idx_q == CntW'(NumVertices - 1)) state_d = StIdle;
      StRdU:    state_d = (oob || cmd_e'(cmd_q) == CmdQuery) ? StOut : StWrU;
      StWrU:    state_d = StRdV;
      StRdV:    state_d = StWrV;
      StWrV:    state_d = StOut;
      StScan: begin
        if (idx_q > CntW'(n_m1)) state_d = StEmit;
        else if (!vis_q[idx_q[VtxW-1:0]]) state_d = StPop;
      end
      StPop:    state_d = (sp_q == '0) ? StScan : StNbr;
      StNbr:    if (nb_d == '0) state_d = StPop;
      StEmit:   if (!out_valid_q || m_axis_tready) state_d = StEmitRd;
      StEmitRd: state_d = StOut;
      StOut:    if (!out_valid_q || m_axis_tready) state_d = ret_q;
      default:  state_d = StIdle;
    endcase
  end

  always_comb begin
    ret_d = ret_q;
    idx_d = idx_q;
    vis_d = vis_q;
    nb_d = nb_q;
    sp_d = sp_q;
    lab_d = lab_q;
    out_valid_d = out_valid_q;
    out_last_d = out_last_q;
    out_data_d = out_data_q;
    adj_we = 1'b0;
    adj_wa = u_q;
    adj_wd = '0;
    adj_ra = u_q;
    lbl_we = 1'b0;
    lbl_wa = '0;
    lbl_wd = lab_q;
    lbl_ra = idx_q[VtxW-1:0];
    stk_we = 1'b0;
    stk_wa = sp_q[VtxW-1:0];
    stk_wd = '0;
    stk_ra = VtxW'(sp_q - CntW'(1));
    s_axis_tready = 1'b0;
    if (out_valid_q && m_axis_tready && state_q != StOut) out_valid_d = 1'b0;
    case (state_q)
      StClear: begin
        adj_we = 1'b1;
        adj_wa = idx_q[VtxW-1:0];
        idx_d = idx_q + CntW'(1);
        if (idx_q == CntW'(NumVertices - 1)) idx_d = '0;
      end
      StIdle: begin
        s_axis_tready = !out_valid_q;
        adj_ra = s_axis_tdata[7:2];
        if (s_axis_tvalid && s_axis_tready) begin
          idx_d = '0;
          vis_d = '0;
          lab_d = '0;
          sp_d = '0;
        end
      end
      StRdU: begin
        ret_d = StIdle;
        out_data_d = {2'b0, 6'd0, 6'd0, 1'b0, oob};
        out_last_d = 1'b1;
        if (!oob && cmd_e'(cmd_q) == CmdQuery) out_data_d[1] = row_q[v_q];
      end
      StWrU: begin
        adj_we = 1'b1;
        adj_wa = u_q;
        adj_wd = row_q;
        adj_wd[v_q] = (cmd_e'(cmd_q) == CmdInsert);
        adj_ra = v_q;
      end
      StRdV: adj_ra = v_q;
      StWrV: begin
        adj_we = 1'b1;
        adj_wa = v_q;
        adj_wd = row_q;
        adj_wd[u_q] = (cmd_e'(cmd_q) == CmdInsert);
      end
      StScan: begin
        if (idx_q > CntW'(n_m1)) begin
          idx_d = '0;
        end else if (vis_q[idx_q[VtxW-1:0]]) begin
          idx_d = idx_q + CntW'(1);
        end else begin
          vis_d[idx_q[VtxW-1:0]] = 1'b1;
          lbl_we = 1'b1;
          lbl_wa = idx_q[VtxW-1:0];
          stk_we = 1'b1;
          stk_wa = '0;
          stk_wd = idx_q[VtxW-1:0];
          sp_d = CntW'(1);
          stk_ra = '0;
        end
      end
      StPop: begin
        if (sp_q == '0) begin
          lab_d = lab_q + VtxW'(1);
          idx_d = idx_q + CntW'(1);
        end else begin
          adj_ra = stk_top;
          sp_d = sp_q - CntW'(1);
        end
      end
      StNbr: begin
        if (nb_q == '0) begin
          nb_d = row_q & inuse & ~vis_q;
        end else begin
          vis_d[nb_first] = 1'b1;
          nb_d[nb_first] = 1'b0;
          lbl_we = 1'b1;
          lbl_wa = nb_first;
          stk_we = 1'b1;
          stk_wd = nb_first;
          sp_d = sp_q + CntW'(1);
        end
        stk_ra = VtxW'(sp_d - CntW'(1));
      end
      StEmit: lbl_ra = idx_q[VtxW-1:0];
      StEmitRd: begin
        out_data_d = {2'b0, lbl_rd_q, idx_q[VtxW-1:0], 2'b00};
        out_last_d = (idx_q[VtxW-1:0] == n_m1);
        ret_d = (idx_q[VtxW-1:0] == n_m1) ? StIdle : StEmit;
        idx_d = idx_q + CntW'(1);
      end
      StOut: begin
        if (!out_valid_q || m_axis_tready) out_valid_d = 1'b1;
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata = out_data_q;
  assign m_axis_tlast = out_last_q;
endmodule

FILE: tb/graph_edge_store_component_labeler_test.sv
// Testbench that checks edge commands and component labelling against a behavioural graph model.
`timescale 1ns / 1ps
module graph_edge_store_component_labeler_test;
  import gesl_pkg::*;

  typedef struct packed {
    logic       is_cfg;
    logic [6:0] count;
    cmd_e       cmd;
    logic [5:0] vu;
    logic [5:0] vv;
  } pending_t;

  typedef struct packed {
    logic       status;
    logic       present;
    logic [5:0] vidx;
    logic [5:0] label;
    logic       tlast;
  } result_t;

  localparam int unsigned IdleLimit = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [6:0] cfg_wdata_i = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic m_axis_tlast;

  pending_t pending_q[$];
  result_t expected_q[$];
  logic [63:0] adj_rows[64];
  logic [6:0] vtx_count;
  int unsigned mismatches = 0;
  int unsigned beats_in = 0;
  int unsigned beats_out = 0;
  int unsigned labellings = 0;
  int unsigned idle_cycles = 0;
  int unsigned send_gap = 0;
  int unsigned recv_gap = 0;
  bit quiet = 1'b0;
  bit hold = 1'b0;
  bit feed_done = 1'b0;
  bit timed_out = 1'b0;

  always #10 clk_i = ~clk_i;

  graph_edge_store_component_labeler dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tlast(m_axis_tlast)
  );

  function automatic int unsigned active_vertices();
    int unsigned n;
    n = 32'(vtx_count);
    if (n < 1) n = 1;
    if (n > 64) n = 64;
    return n;
  endfunction

  task automatic predict_command(input pending_t p);
    int unsigned n;
    logic [63:0] inuse;
    logic [63:0] seen;
    logic [5:0] labels[64];
    logic [5:0] stack[$];
    logic [5:0] x;
    logic [63:0] nb;
    logic [5:0] next_lbl;
    result_t r;
    n = active_vertices();
    r = '0;
    r.tlast = 1'b1;
    if (p.cmd == CmdLabel) begin
      inuse = (n >= 64) ? '1 : ((64'd1 << n) - 64'd1);
      seen = '0;
      next_lbl = '0;
      for (int i = 0; i < n; i++) begin
        if (!seen[i]) begin
          seen[i] = 1'b1;
          labels[i] = next_lbl;
          stack.push_back(i[5:0]);
          while (stack.size() > 0) begin
            x = stack.pop_back();
            nb = adj_rows[x] & inuse & ~seen;
            for (int j = 0; j < 64; j++) begin
              if (nb[j]) begin
                seen[j] = 1'b1;
                labels[j] = next_lbl;
                stack.push_back(j[5:0]);
              end
            end
          end
          next_lbl = next_lbl + 6'd1;
        end
      end
      for (int i = 0; i < n; i++) begin
        r.vidx = i[5:0];
        r.label = labels[i];
        r.tlast = (i + 1 == n);
        expected_q.push_back(r);
      end
    end else if (p.vu >= n || p.vv >= n) begin
      r.status = 1'b1;
      expected_q.push_back(r);
    end else begin
      case (p.cmd)
        CmdInsert: begin
          adj_rows[p.vu][p.vv] = 1'b1;
          adj_rows[p.vv][p.vu] = 1'b1;
        end
        CmdRemove: begin
          adj_rows[p.vu][p.vv] = 1'b0;
          adj_rows[p.vv][p.vu] = 1'b0;
        end
        default: r.present = adj_rows[p.vu][p.vv];
      endcase
      expected_q.push_back(r);
    end
  endtask

  always @(posedge clk_i) begin
    pending_t p;
    logic cfg_we;
    if (rst_ni) begin
      cfg_we = 1'b0;
      if (s_axis_tvalid && s_axis_tready) begin
        beats_in <= beats_in + 1;
      end
      if (s_axis_tvalid && !s_axis_tready) begin
      end else if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        s_axis_tvalid <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        send_gap <= $urandom_range(0, 4);
        s_axis_tvalid <= 1'b0;
      end else if (pending_q.size() > 0 && !hold &&
                   !(pending_q[0].is_cfg && (expected_q.size() > 0 || s_axis_tvalid))) begin
        p = pending_q.pop_front();
        if (p.is_cfg) begin
          cfg_we = 1'b1;
          cfg_wdata_i <= p.count;
          vtx_count = p.count;
          s_axis_tvalid <= 1'b0;
          send_gap <= 200;
        end else begin
          predict_command(p);
          if (p.cmd == CmdLabel) labellings <= labellings + 1;
          s_axis_tdata <= {2'b00, p.vv, p.vu, p.cmd};
          s_axis_tvalid <= 1'b1;
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
      cfg_we_i <= cfg_we;
    end
  end

  always @(posedge clk_i) begin
    result_t got;
    result_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        beats_out <= beats_out + 1;
        got = '{m_axis_tdata[0], m_axis_tdata[1], m_axis_tdata[7:2], m_axis_tdata[13:8],
                m_axis_tlast};
        if (expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result beat %p", got);
        end else begin
          want = expected_q.pop_front();
          if (got !== want || m_axis_tdata[15:14] !== 2'b00) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch: expected %p got %p", want, got);
          end
        end
      end
      if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        m_axis_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        recv_gap <= $urandom_range(0, 4);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i)
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit && !timed_out) begin
        timed_out = 1'b1;
        $display("simulation failed");
        $finish;
      end
    end
  end

  task automatic add_cmd(input cmd_e c, input logic [5:0] u, input logic [5:0] v);
    pending_t p;
    p = '0;
    p.cmd = c;
    p.vu = u;
    p.vv = v;
    pending_q.push_back(p);
  endtask

  task automatic add_cfg(input logic [6:0] n);
    pending_t p;
    p = '0;
    p.is_cfg = 1'b1;
    p.count = n;
    pending_q.push_back(p);
  endtask

  task automatic add_random_phase(input int unsigned items, input int unsigned span);
    int unsigned k;
    for (int i = 0; i < items; i++) begin
      k = $urandom_range(0, 99);
      if (k < 40)
        add_cmd(CmdInsert, 6'($urandom_range(0, span - 1)), 6'($urandom_range(0, span - 1)));
      else if (k < 55)
        add_cmd(CmdRemove, 6'($urandom_range(0, span - 1)), 6'($urandom_range(0, span - 1)));
      else if (k < 80)
        add_cmd(CmdQuery, 6'($urandom_range(0, span - 1)), 6'($urandom_range(0, span - 1)));
      else if (k < 88)
        add_cmd(CmdLabel, 6'($urandom), 6'($urandom));
      else
        add_cmd(cmd_e'($urandom_range(0, 2)), 6'($urandom), 6'($urandom));
    end
  endtask

  initial begin
    for (int i = 0; i < 64; i++) adj_rows[i] = '0;
    vtx_count = 7'd64;
    add_cmd(CmdLabel, 6'd0, 6'd0);
    add_cmd(CmdInsert, 6'd0, 6'd63);
    add_cmd(CmdInsert, 6'd0, 6'd63);
    add_cmd(CmdQuery, 6'd63, 6'd0);
    add_cmd(CmdInsert, 6'd5, 6'd5);
    add_cmd(CmdQuery, 6'd5, 6'd5);
    add_cmd(CmdInsert, 6'd2, 6'd3);
    add_cmd(CmdInsert, 6'd3, 6'd40);
    add_cmd(CmdLabel, 6'd63, 6'd63);
    add_cmd(CmdRemove, 6'd63, 6'd0);
    add_cmd(CmdQuery, 6'd0, 6'd63);
    add_cfg(7'd4);
    add_cmd(CmdInsert, 6'd4, 6'd1);
    add_cmd(CmdQuery, 6'd1, 6'd63);
    add_cmd(CmdRemove, 6'd3, 6'd3);
    add_cmd(CmdLabel, 6'd0, 6'd0);
    add_cfg(7'd0);
    add_cmd(CmdQuery, 6'd0, 6'd0);
    add_cmd(CmdInsert, 6'd0, 6'd1);
    add_cmd(CmdLabel, 6'd0, 6'd0);
    add_cfg(7'd127);
    add_cmd(CmdLabel, 6'd0, 6'd0);
    add_cfg(7'd12);
    add_random_phase(120, 14);
    add_cfg(7'd64);
    add_random_phase(110, 64);
    add_cfg(7'd1);
    add_random_phase(20, 2);
    add_cfg(7'd9);
    add_random_phase(100, 10);
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    // Hold the sender back once, near halfway, until everything sent has fully drained.
    wait (pending_q.size() <= 190);
    hold = 1'b1;
    wait (expected_q.size() == 0 && !s_axis_tvalid);
    @(posedge clk_i);
    hold = 1'b0;
    wait (pending_q.size() <= 60);
    quiet = 1'b1;
    wait (pending_q.size() == 0);
    @(posedge clk_i);
    wait (!s_axis_tvalid && expected_q.size() == 0);
    repeat (300) @(posedge clk_i);
    $display("%0d commands sent, %0d result beats checked, %0d labelling walks",
             beats_in, beats_out, labellings);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
